### rtl/nrmc_pkg.sv
// Shared types, character codes and constant tables for the RMC position parser.
`timescale 1ns / 1ps

package nrmc_pkg;

    // Field and state widths
    localparam int ACC_W       = 30;
    localparam int FIELD_IDX_W = 4;
    localparam int CHAR_CNT_W  = 7;
    localparam int FRAC_CNT_W  = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * ACC_W + 2);

    // Saturation ceiling for both coordinates
    localparam logic [ACC_W-1:0] VALUE_MAX = 30'd999999999;

    // Character codes
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_STAT_A = 8'h41;

    // Field positions in the sentence
    localparam logic [FIELD_IDX_W-1:0] FLD_HEADER = 4'd0;
    localparam logic [FIELD_IDX_W-1:0] FLD_STATUS = 4'd2;
    localparam logic [FIELD_IDX_W-1:0] FLD_LAT    = 4'd3;
    localparam logic [FIELD_IDX_W-1:0] FLD_LON    = 4'd5;
    localparam logic [FIELD_IDX_W-1:0] FLD_MAX    = 4'd15;

    localparam logic [CHAR_CNT_W-1:0] HDR_LEN      = 7'd6;
    localparam logic [CHAR_CNT_W-1:0] CHAR_CNT_MAX = 7'd127;

    // Number conversion state shared by the latitude and longitude fields
    typedef struct packed {
        logic                  after_point;
        logic [FRAC_CNT_W-1:0] frac_count;
        logic                  parse_stop;
    } t_num_state;

    // One parsed sentence result
    typedef struct packed {
        logic             overflow_flag;
        logic [ACC_W-1:0] longitude_e4;
        logic [ACC_W-1:0] latitude_e4;
        logic             fix_valid;
    } t_result;

    // Expected sentence header "$GNRMC"
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h4E;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4D;
            3'd5:    ch = 8'h43;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Powers of ten used as digit weights
    function automatic logic [19:0] pow10_f(input logic [2:0] idx);
        logic [19:0] p;
        case (idx)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

endpackage

### rtl/nrmc_num_accum.sv
// Decimal fixed-point digit accumulator for one coordinate character.
`timescale 1ns / 1ps

module nrmc_num_accum #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic [7:0]                i_char,
    input  logic [nrmc_pkg::ACC_W-1:0] i_acc,
    input  nrmc_pkg::t_num_state      i_ns,
    output logic [nrmc_pkg::ACC_W-1:0] o_acc,
    output nrmc_pkg::t_num_state      o_ns,
    output logic                      o_sat
);

    localparam int VW = nrmc_pkg::ACC_W + 4;
    localparam logic [19:0] SCALE = nrmc_pkg::pow10_f(3'(FRACTION_DIGITS));
    localparam logic [nrmc_pkg::FRAC_CNT_W-1:0] FD = nrmc_pkg::FRAC_CNT_W'(FRACTION_DIGITS);

    logic                                is_digit;
    logic [3:0]                          digit;
    logic [nrmc_pkg::FRAC_CNT_W-1:0]     frac_next;
    logic [VW-1:0]                       v_int;
    logic [VW-1:0]                       v_frac;
    logic [VW-1:0]                       v;
    logic                                use_value;

    assign is_digit  = (i_char >= nrmc_pkg::CH_ZERO) && (i_char <= nrmc_pkg::CH_NINE);
    assign digit     = 4'(i_char - nrmc_pkg::CH_ZERO);
    assign frac_next = i_ns.frac_count + 1'b1;

    // Integer digit shifts the value; fraction digit adds at its weight
    assign v_int  = ({4'b0, i_acc} * VW'(10)) + (VW'(digit) * VW'(SCALE));
    assign v_frac = {4'b0, i_acc}
                  + (VW'(digit) * VW'(nrmc_pkg::pow10_f(FD - frac_next)));

    always_comb begin
        o_ns      = i_ns;
        v         = {4'b0, i_acc};
        use_value = 1'b0;
        if (!i_ns.parse_stop) begin
            if (is_digit) begin
                use_value = 1'b1;
                if (!i_ns.after_point) begin
                    v = v_int;
                end else if (i_ns.frac_count < FD) begin
                    o_ns.frac_count = frac_next;
                    v = v_frac;
                end
            end else if ((i_char == nrmc_pkg::CH_POINT) && !i_ns.after_point) begin
                o_ns.after_point = 1'b1;
            end else begin
                o_ns.parse_stop = 1'b1;
            end
        end
    end

    // Clamp at the ceiling
    always_comb begin
        o_sat = 1'b0;
        o_acc = i_acc;
        if (use_value) begin
            if (v > VW'(nrmc_pkg::VALUE_MAX)) begin
                o_sat = 1'b1;
                o_acc = nrmc_pkg::VALUE_MAX;
            end else begin
                o_acc = v[nrmc_pkg::ACC_W-1:0];
            end
        end
    end

endmodule

### rtl/nrmc_field_parser.sv
// Sentence state and per-character field parsing, one character per request.
`timescale 1ns / 1ps

module nrmc_field_parser #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_char,
    input  logic               i_last,
    output logic               o_emit,
    output nrmc_pkg::t_result  o_result
);

    logic [nrmc_pkg::FIELD_IDX_W-1:0] r_field_index, n_field_index;
    logic [nrmc_pkg::CHAR_CNT_W-1:0]  r_char_in_field, n_char_in_field;
    logic                             r_header_match, n_header_match;
    logic                             r_status_is_a, n_status_is_a;
    nrmc_pkg::t_num_state             r_ns, n_ns;
    logic [nrmc_pkg::ACC_W-1:0]       r_lat_accum, n_lat_accum;
    logic [nrmc_pkg::ACC_W-1:0]       r_lon_accum, n_lon_accum;
    logic                             r_saturated, n_saturated;

    logic                             is_cr;
    logic                             is_lf;
    logic                             is_comma;
    logic                             in_lat;
    logic                             close_now;
    logic                             hdr_final;
    logic [nrmc_pkg::ACC_W-1:0]       acc_in;
    logic [nrmc_pkg::ACC_W-1:0]       acc_out;
    nrmc_pkg::t_num_state             ns_out;
    logic                             acc_sat;

    assign is_cr    = (i_char == nrmc_pkg::CH_CR);
    assign is_lf    = (i_char == nrmc_pkg::CH_LF);
    assign is_comma = (i_char == nrmc_pkg::CH_COMMA);
    assign in_lat   = (r_field_index == nrmc_pkg::FLD_LAT);
    assign acc_in   = in_lat ? r_lat_accum : r_lon_accum;

    // One shared converter; only one coordinate field is open at a time
    nrmc_num_accum #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_num_accum (
        .i_char (i_char),
        .i_acc  (acc_in),
        .i_ns   (r_ns),
        .o_acc  (acc_out),
        .o_ns   (ns_out),
        .o_sat  (acc_sat)
    );

    // State after taking this character (CR and LF take nothing)
    always_comb begin
        n_field_index   = r_field_index;
        n_char_in_field = r_char_in_field;
        n_header_match  = r_header_match;
        n_status_is_a   = r_status_is_a;
        n_ns            = r_ns;
        n_lat_accum     = r_lat_accum;
        n_lon_accum     = r_lon_accum;
        n_saturated     = r_saturated;
        if (!is_cr && !is_lf) begin
            if (is_comma) begin
                if ((r_field_index == nrmc_pkg::FLD_HEADER)
                        && (r_char_in_field != nrmc_pkg::HDR_LEN)) begin
                    n_header_match = 1'b0;
                end
                if (r_field_index != nrmc_pkg::FLD_MAX) begin
                    n_field_index = r_field_index + 1'b1;
                end
                n_char_in_field = '0;
                n_ns            = '0;
            end else begin
                if (r_field_index == nrmc_pkg::FLD_HEADER) begin
                    if ((r_char_in_field >= nrmc_pkg::HDR_LEN)
                            || (i_char != nrmc_pkg::hdr_char(r_char_in_field[2:0]))) begin
                        n_header_match = 1'b0;
                    end
                end else if (r_field_index == nrmc_pkg::FLD_STATUS) begin
                    n_status_is_a = (r_char_in_field == '0)
                                 && (i_char == nrmc_pkg::CH_STAT_A);
                end else if (in_lat) begin
                    n_lat_accum = acc_out;
                    n_ns        = ns_out;
                    n_saturated = r_saturated | acc_sat;
                end else if (r_field_index == nrmc_pkg::FLD_LON) begin
                    n_lon_accum = acc_out;
                    n_ns        = ns_out;
                    n_saturated = r_saturated | acc_sat;
                end
                if (r_char_in_field != nrmc_pkg::CHAR_CNT_MAX) begin
                    n_char_in_field = r_char_in_field + 1'b1;
                end
            end
        end
    end

    // Sentence close: final header check and result build
    assign close_now = is_cr || i_last;
    assign hdr_final = n_header_match
                    && !((n_field_index == nrmc_pkg::FLD_HEADER)
                         && (n_char_in_field != nrmc_pkg::HDR_LEN));
    assign o_emit    = i_step && close_now && hdr_final;

    always_comb begin
        o_result = '0;
        if (n_status_is_a) begin
            o_result.fix_valid     = 1'b1;
            o_result.latitude_e4   = n_lat_accum;
            o_result.longitude_e4  = n_lon_accum;
            o_result.overflow_flag = n_saturated;
        end
    end

    // Sentence state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && close_now)) begin
            r_field_index   <= '0;
            r_char_in_field <= '0;
            r_header_match  <= 1'b1;
            r_status_is_a   <= 1'b0;
            r_ns            <= '0;
            r_lat_accum     <= '0;
            r_lon_accum     <= '0;
            r_saturated     <= 1'b0;
        end else if (i_step) begin
            r_field_index   <= n_field_index;
            r_char_in_field <= n_char_in_field;
            r_header_match  <= n_header_match;
            r_status_is_a   <= n_status_is_a;
            r_ns            <= n_ns;
            r_lat_accum     <= n_lat_accum;
            r_lon_accum     <= n_lon_accum;
            r_saturated     <= n_saturated;
        end
    end

endmodule

### rtl/nmea_rmc_position_parser.sv
// Top level: NMEA RMC sentence parser with registered input and result stages.
`timescale 1ns / 1ps

// Usage:
//  Slave stream (s_axis_*) carries one received character per request in
//  tdata; tlast marks the last byte of a buffer and closes the sentence.
//  CR also closes a sentence, LF is ignored, commas split fields.
//  Master stream (m_axis_*) carries one result per closed $GNRMC sentence:
//  fix flag, latitude and longitude scaled by 10^FRACTION_DIGITS, and an
//  overflow flag. Other sentences give no result.
//  The closing character is loaded into the input register when accepted,
//  and its parse result then goes into the result register once that is free.
//  Throughput: one character per cycle while the result register is free;
//  the sentence state loop is a single compare and multiply-by-ten
//  accumulate per character.
//  Reset clears both stage valids and the sentence state; the next character
//  starts a new sentence.
//  When the receiver stalls, the result holds in its register and one more
//  character waits in the input register; characters that make no result
//  keep flowing only while the result register is free.
module nmea_rmc_position_parser #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [nrmc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [7:0] in_char
    input  logic                                s_axis_tlast,  // last_char
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] fix_valid, [30:1] latitude_e4, [60:31] longitude_e4,
    // [61] overflow_flag, [63:62] zero
    output logic [nrmc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic              r_in_valid;
    logic [7:0]        r_in_char;
    logic              r_in_last;
    logic              r_out_valid;
    nrmc_pkg::t_result r_out;

    logic              slot_free;
    logic              step;
    logic              emit;
    nrmc_pkg::t_result result;

    assign slot_free     = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && slot_free;
    assign s_axis_tready = !r_in_valid || slot_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    nrmc_field_parser #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_field_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_emit   (emit),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{nrmc_pkg::OUT_PAD_W{1'b0}}, r_out};

    // A result without a fix carries only zeros
    a_nofix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.fix_valid) |->
            (r_out.latitude_e4 == '0) && (r_out.longitude_e4 == '0) && !r_out.overflow_flag)
        else $error("non-fix result carries nonzero values");

    // Coordinates never exceed the saturation ceiling
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (r_out.latitude_e4 <= nrmc_pkg::VALUE_MAX)
            && (r_out.longitude_e4 <= nrmc_pkg::VALUE_MAX))
        else $error("coordinate above ceiling");

    // A free result slot always lets a character in
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input blocked with free result register");

    // A new result comes only from a character held in the input register
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(r_in_valid))
        else $error("result without a parsed character");

endmodule
